// ===== hdl/lpe_pkg.sv =====
// Lognormal peak evaluator package: fixed-point constants, latencies,
// register indexes and status codes. No dependencies.
package lpe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IFR           = 28;

  // ln2, 1/(2 ln2), ln2/2 in Q.28
  localparam logic [27:0] LN2_Q     = 28'd186065279;
  localparam logic [27:0] INV2LN2_Q = 28'd193635251;
  localparam logic [26:0] HALFLN2_Q = 27'd93032640;

  localparam logic [33:0] CAP_U     = 34'd20 << IFR;
  localparam logic [35:0] CAP_DECAY = 36'd128 << IFR;
  localparam logic [33:0] SAT_MAG   = 34'd1 << 33;

  localparam int LOG_LAT  = 30;
  localparam int POW_LAT  = 26;
  localparam int DIV_BITS = 34;

  typedef enum logic [2:0] {
    CFG_AMPLITUDE     = 3'd0,
    CFG_MEDIAN_MU     = 3'd1,
    CFG_WIDTH_SIGMA   = 3'd2,
    CFG_PEAK_LOCATION = 3'd3,
    CFG_BACKGROUND    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_SAT     = 2'd2
  } status_t;

endpackage

// ===== hdl/lognormal_peak_evaluator.sv =====
// Lognormal peak evaluator top level: config registers, log-domain datapath.
// Depends on lpe_pkg, lpe_log2, lpe_pow2.
//
//  channel   ports                                   handshake
//  input     start, busy, in_abscissa                start & !busy
//  result    out_valid, out_value, out_status        one-cycle strobe
//  config    cfg_we, cfg_addr, cfg_wdata             write on cfg_we
//
// One word enters per cycle. The pipeline depth is set by the two 28-stage
// squaring logarithm chains, the 34-stage restoring divider and the
// 26-stage series exponent.
// Reset (synchronous, rst_n low) clears valid bits and loads register
// defaults. busy never rises: the pipeline has no stall path.
module lognormal_peak_evaluator #(
  parameter int FRAC_BITS = lpe_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_abscissa,
  output logic               out_valid,
  output logic signed [31:0] out_value,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);

  localparam int ST_LOG = 1 + lpe_pkg::LOG_LAT;
  localparam int ST_D   = ST_LOG + 1;
  localparam int ST_W   = ST_D + 2 + lpe_pkg::DIV_BITS + 5;
  localparam int ST_Q   = ST_W + lpe_pkg::POW_LAT + 2;
  localparam int D_DLY  = ST_W - 1 - ST_D;
  localparam int K_DLY  = lpe_pkg::POW_LAT + 1;
  localparam int NDIV   = lpe_pkg::DIV_BITS;

  // configuration
  logic signed [31:0] amp_r, mu_r, sig_r, loc_r, bg_r;
  logic [31:0] sr_r, aabs_r;
  logic [45:0] s14;
  logic        sbig_r;
  logic [35:0] s2_r;
  logic [63:0] st_prod;
  logic [35:0] sterm_r;
  logic        invalid;
  logic        aneg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r <= 32'(64'd1 << FRAC_BITS);
      mu_r  <= 32'(64'd1 << FRAC_BITS);
      sig_r <= 32'(64'd1 << FRAC_BITS);
      loc_r <= '0;
      bg_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lpe_pkg::CFG_AMPLITUDE:     amp_r <= cfg_wdata;
        lpe_pkg::CFG_MEDIAN_MU:     mu_r  <= cfg_wdata;
        lpe_pkg::CFG_WIDTH_SIGMA:   sig_r <= cfg_wdata;
        lpe_pkg::CFG_PEAK_LOCATION: loc_r <= cfg_wdata;
        lpe_pkg::CFG_BACKGROUND:    bg_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign invalid = mu_r[31] || (mu_r == 32'sd0) || (sig_r == 32'sd0);
  assign aneg    = amp_r[31];

  always_comb begin
    if (FRAC_BITS >= 14) s14 = {14'b0, sr_r} >> (FRAC_BITS - 14);
    else                 s14 = {14'b0, sr_r} << (14 - FRAC_BITS);
  end

  assign st_prod = s2_r * lpe_pkg::INV2LN2_Q;

  // sigma and amplitude terms are registered behind the config registers
  always_ff @(posedge clk) begin
    sr_r    <= sig_r[31] ? 32'(-sig_r) : 32'(sig_r);
    aabs_r  <= amp_r[31] ? 32'(-amp_r) : 32'(amp_r);
    sbig_r  <= s14 >= (46'd16 << 14);
    s2_r    <= s14[17:0] * s14[17:0];
    sterm_r <= st_prod[63:28];
  end

  // valid and onset flags per stage
  logic [ST_Q-1:0] vld_r;
  logic [ST_Q-1:0] np_r;
  logic signed [32:0] z_nxt;
  logic signed [32:0] z_r;

  assign busy  = 1'b0;
  assign z_nxt = 33'(in_abscissa) - 33'(loc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[ST_Q-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    np_r <= {np_r[ST_Q-2:0], z_nxt[32] || (z_nxt == 33'sd0)};
    z_r  <= z_nxt;
  end

  // logarithms of z and mu
  logic signed [35:0] lz, lmu;

  lpe_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_z (
    .clk(clk), .in_val(z_r[31:0]), .log_val(lz)
  );
  lpe_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_mu (
    .clk(clk), .in_val(mu_r), .log_val(lmu)
  );

  logic signed [36:0] d_r;
  logic signed [36:0] dneg;
  logic [35:0] absd_r;
  logic signed [36:0] d_dly_r [0:D_DLY-1];

  assign dneg = -d_r;

  always_ff @(posedge clk) begin
    d_r    <= 37'(lz) - 37'(lmu);
    absd_r <= d_r[36] ? dneg[35:0] : d_r[35:0];
    d_dly_r[0] <= d_r;
    for (int i = 1; i < D_DLY; i++) d_dly_r[i] <= d_dly_r[i-1];
  end

  // |D| * 2^F / |sigma|, one quotient bit per stage
  logic [65:0] num;
  logic [65:0] rem_r [0:NDIV];
  logic [33:0] quo_r [0:NDIV];
  logic        ovf_r [0:NDIV];

  assign num = {30'b0, absd_r} << FRAC_BITS;

  always_ff @(posedge clk) begin
    rem_r[0] <= num;
    quo_r[0] <= '0;
    ovf_r[0] <= num[65:34] >= sr_r;
  end

  for (genvar g = 1; g <= NDIV; g++) begin : g_div
    logic [65:0] trial;
    logic        ge;
    assign trial = {34'b0, sr_r} << (NDIV - g);
    assign ge    = rem_r[g-1] >= trial;
    always_ff @(posedge clk) begin
      rem_r[g] <= ge ? rem_r[g-1] - trial : rem_r[g-1];
      quo_r[g] <= {quo_r[g-1][32:0], ge};
      ovf_r[g] <= ovf_r[g-1];
    end
  end

  // shape and width terms of the decay
  logic [32:0] u_r;
  logic [37:0] uh2_r;
  logic [64:0] d1_prod;
  logic [36:0] d1_r;
  logic [37:0] dsum;
  logic [35:0] decay_r;
  logic signed [38:0] w_r;

  assign d1_prod = uh2_r * lpe_pkg::HALFLN2_Q;
  assign dsum    = 38'(d1_r) + 38'(sterm_r);

  always_ff @(posedge clk) begin
    if (ovf_r[NDIV] || quo_r[NDIV] > lpe_pkg::CAP_U) u_r <= lpe_pkg::CAP_U[32:0];
    else                                              u_r <= quo_r[NDIV][32:0];
    uh2_r <= u_r[32:14] * u_r[32:14];
    d1_r  <= d1_prod[64:28];
    if (sbig_r || dsum > 38'(lpe_pkg::CAP_DECAY)) decay_r <= lpe_pkg::CAP_DECAY;
    else                                          decay_r <= dsum[35:0];
    w_r <= -39'(d_dly_r[D_DLY-1]) - 39'(decay_r);
  end

  // 2^frac, integer part waits alongside
  logic [29:0] pw;
  logic signed [10:0] k_dly_r [0:K_DLY-1];

  lpe_pow2 u_pow2 (.clk(clk), .frac(w_r[27:0]), .pow_val(pw));

  always_ff @(posedge clk) begin
    k_dly_r[0] <= w_r[38:28];
    for (int i = 1; i < K_DLY; i++) k_dly_r[i] <= k_dly_r[i-1];
  end

  logic [61:0] mag_r;
  logic [33:0] q_r;
  logic [33:0] q_nxt;
  logic signed [11:0] ek;
  logic signed [11:0] er;
  logic [95:0] wide;
  logic [61:0] shr;

  always_ff @(posedge clk) begin
    mag_r <= aabs_r * pw;
  end

  // scale by 2^k, clamp the magnitude at 2^33
  always_comb begin
    ek    = 12'(k_dly_r[K_DLY-1]) - 12'sd28;
    er    = -ek;
    wide  = {34'b0, mag_r} << ek[5:0];
    shr   = mag_r >> er[5:0];
    q_nxt = '0;
    if (mag_r == '0) begin
      q_nxt = '0;
    end else if (!ek[11] && ek != 12'sd0) begin
      if (ek >= 12'sd34)                      q_nxt = lpe_pkg::SAT_MAG;
      else if (wide > 96'(lpe_pkg::SAT_MAG))  q_nxt = lpe_pkg::SAT_MAG;
      else                                    q_nxt = wide[33:0];
    end else begin
      if (er >= 12'sd62)                      q_nxt = '0;
      else if (shr > 62'(lpe_pkg::SAT_MAG))   q_nxt = lpe_pkg::SAT_MAG;
      else                                    q_nxt = shr[33:0];
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  // sign, background, saturation
  logic signed [35:0] sq;
  logic signed [35:0] tot;
  logic signed [31:0] value_nxt;
  logic [1:0]         status_nxt;
  logic signed [31:0] out_value_r;
  logic [1:0]         out_status_r;
  logic               out_valid_r;

  assign sq  = aneg ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  assign tot = sq + 36'(bg_r);

  always_comb begin
    priority if (invalid) begin
      value_nxt  = '0;
      status_nxt = lpe_pkg::STAT_INVALID;
    end else if (np_r[ST_Q-1]) begin
      value_nxt  = bg_r;
      status_nxt = lpe_pkg::STAT_OK;
    end else if (tot > 36'sh0_7FFF_FFFF) begin
      value_nxt  = 32'sh7FFF_FFFF;
      status_nxt = lpe_pkg::STAT_SAT;
    end else if (tot < -36'sh0_8000_0000) begin
      value_nxt  = 32'sh8000_0000;
      status_nxt = lpe_pkg::STAT_SAT;
    end else begin
      value_nxt  = tot[31:0];
      status_nxt = lpe_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= vld_r[ST_Q-1];
    out_value_r  <= value_nxt;
    out_status_r <= status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(ST_Q+1) out_valid)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, ST_Q+1))
    else $error("result without an accepted word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == lpe_pkg::STAT_INVALID |-> out_value == 32'sd0)
    else $error("invalid parameters with nonzero value");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == lpe_pkg::STAT_SAT |->
      out_value == 32'sh7FFF_FFFF || out_value == 32'sh8000_0000)
    else $error("saturation flagged off the limits");

endmodule

// ===== hdl/lpe_log2.sv =====
// Pipelined base-2 logarithm of a positive raw fixed-point word, Q.28 result.
// Depends on lpe_pkg. One word per cycle.
module lpe_log2 #(
  parameter int FRAC_BITS = lpe_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic [31:0]        in_val,
  output logic signed [35:0] log_val
);

  localparam int NSTEP = lpe_pkg::IFR;

  logic [31:0] v_r;
  logic [4:0]  msb_r;
  logic [4:0]  msb_nxt;
  logic [31:0] norm;

  logic [28:0] m_r  [0:NSTEP];
  logic [27:0] fr_r [0:NSTEP];
  logic [4:0]  n_r  [0:NSTEP];

  logic signed [7:0] nm;

  // leading-one position
  always_comb begin
    msb_nxt = '0;
    for (int i = 1; i < 32; i++) begin
      if (in_val[i]) msb_nxt = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= in_val;
    msb_r <= msb_nxt;
  end

  // bring the word to [1,2) in Q.28, truncating
  always_comb begin
    if (msb_r >= 5'd28) norm = v_r >> (msb_r - 5'd28);
    else                norm = v_r << (5'd28 - msb_r);
  end

  always_ff @(posedge clk) begin
    m_r[0]  <= norm[28:0];
    fr_r[0] <= '0;
    n_r[0]  <= msb_r;
  end

  // one fraction bit per stage by repeated squaring
  for (genvar g = 1; g <= NSTEP; g++) begin : g_sq
    logic [57:0] sq;
    logic [29:0] sqh;
    assign sq  = m_r[g-1] * m_r[g-1];
    assign sqh = sq[57:28];
    always_ff @(posedge clk) begin
      n_r[g] <= n_r[g-1];
      if (sqh[29]) begin
        m_r[g]  <= sqh[29:1];
        fr_r[g] <= {fr_r[g-1][26:0], 1'b1};
      end else begin
        m_r[g]  <= sqh[28:0];
        fr_r[g] <= {fr_r[g-1][26:0], 1'b0};
      end
    end
  end

  assign nm      = $signed({3'b000, n_r[NSTEP]}) - 8'(FRAC_BITS);
  assign log_val = {nm, fr_r[NSTEP]};

endmodule

// ===== hdl/lpe_pow2.sv =====
// Pipelined 2^f for f in [0,1) as Q.28, by the series of e^(f ln2) through the twelfth-order term.
// Depends on lpe_pkg. One word per cycle.
module lpe_pow2 (
  input  logic        clk,
  input  logic [27:0] frac,
  output logic [29:0] pow_val
);

  localparam int NTERM = 12;
  localparam int RSH   = 33;

  logic [55:0] xp;
  logic [27:0] x_r    [0:NTERM];
  logic [28:0] term_r [0:NTERM];
  logic [29:0] sum_r  [0:NTERM];
  logic [56:0] prod_r [1:NTERM];
  logic [29:0] sa_r   [1:NTERM];
  logic [27:0] xa_r   [1:NTERM];
  logic [29:0] pow_val_r;

  assign xp = frac * lpe_pkg::LN2_Q;

  always_ff @(posedge clk) begin
    x_r[0]    <= xp[55:28];
    term_r[0] <= 29'd1 << lpe_pkg::IFR;
    sum_r[0]  <= '0;
  end

  for (genvar g = 1; g <= NTERM; g++) begin : g_term
    // ceil(2^33/n): exact floor division for terms below 2^29
    localparam logic [33:0] RECIP = 34'(((64'd1 << RSH) + 64'(g) - 64'd1) / 64'(g));
    logic [62:0] qp;
    assign qp = prod_r[g][56:28] * RECIP;
    always_ff @(posedge clk) begin
      prod_r[g] <= term_r[g-1] * x_r[g-1];
      sa_r[g]   <= sum_r[g-1] + 30'(term_r[g-1]);
      xa_r[g]   <= x_r[g-1];
      term_r[g] <= qp[61:33];
      sum_r[g]  <= sa_r[g];
      x_r[g]    <= xa_r[g];
    end
  end

  always_ff @(posedge clk) begin
    pow_val_r <= sum_r[NTERM] + 30'(term_r[NTERM]);
  end

  assign pow_val = pow_val_r;

endmodule
